@@ sv/swtc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swtc_pkg
// Shared constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package swtc_pkg;

    localparam int MAX_EDGES_DEF     = 32;
    localparam int MAX_TILE_ROWS_DEF = 16;
    localparam int MAX_TILE_COLS_DEF = 32;

    localparam int CNT_W = 6;   // holds counts up to 32

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INSERT,
        OP_SETUP,
        OP_PREP,
        OP_EMIT_EMPTY,
        OP_EMIT_SLOT,
        OP_EDGE_RD,
        OP_EMIT_EDGE,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        KIND_SLOT  = 2'd0,
        KIND_PLACE = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] ucount;
        logic [CNT_W-1:0] ecount;
        logic             out_free;
    } stat_t;

endpackage
`default_nettype wire

@@ sv/sparse_window_tile_condenser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_window_tile_condenser
// Condenses one row window of sparse edges into dense tile slots/offsets.
// ----------------------------------------------------------------------------
// Edge items are taken back to back (parallel sorted insert).
// Close item: accept, setup, a slot-table prepass over the U unique columns,
// U slot items, E placement items (each an edge read, then a place) and
// a finish step; an empty window goes accept, setup, empty item, finish.
// Output item is registered; bursts stall only while m_tready is low.
// Reset (aresetn low, synchronous): empty window, tile total 0,
// rows_per_tile 16, cols_per_tile 8.
module sparse_window_tile_condenser #(
    parameter int MAX_EDGES     = swtc_pkg::MAX_EDGES_DEF,
    parameter int MAX_TILE_ROWS = swtc_pkg::MAX_TILE_ROWS_DEF,
    parameter int MAX_TILE_COLS = swtc_pkg::MAX_TILE_COLS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [5:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,  // row_in_window, column, value_bits, pad
    input  wire logic         s_tuser,  // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,  // offset, column_out, value_out,
                                        // window_tiles, tile_base, dropped
    output logic [1:0]        m_tuser,  // kind
    output logic              m_tlast
);
    import swtc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    swtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swtc_dp #(
        .MAX_EDGES     (MAX_EDGES),
        .MAX_TILE_ROWS (MAX_TILE_ROWS),
        .MAX_TILE_COLS (MAX_TILE_COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_row    (s_tdata[3:0]),
        .in_col    (s_tdata[34:4]),
        .in_val    (s_tdata[66:35]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

@@ sv/swtc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swtc_ctrl
// Window sequencer: intake, slot table prepass, slot and placement bursts.
// ----------------------------------------------------------------------------
module swtc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_action,
    output logic               s_tready,
    input  swtc_pkg::stat_t    stat,
    output swtc_pkg::cmd_t     cmd
);
    import swtc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_PREP, ST_SLOT, ST_ERD, ST_EOUT, ST_EMPTY, ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.op     = OP_NOP;
        cmd.idx    = idx_reg;
        cmd.last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_action) state_next = ST_SETUP;
                    else          cmd.op     = OP_INSERT;
                end
            end
            ST_SETUP: begin
                cmd.op   = OP_SETUP;
                idx_next = '0;
                state_next = (stat.ecount == '0) ? ST_EMPTY : ST_PREP;
            end
            ST_PREP: begin
                cmd.op = OP_PREP;
                if (idx_reg + 1'b1 == stat.ucount) begin
                    idx_next   = '0;
                    state_next = ST_SLOT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SLOT: begin
                if (stat.out_free) begin
                    cmd.op = OP_EMIT_SLOT;
                    if (idx_reg + 1'b1 == stat.ucount) begin
                        idx_next   = '0;
                        state_next = ST_ERD;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_ERD: begin
                cmd.op     = OP_EDGE_RD;
                state_next = ST_EOUT;
            end
            ST_EOUT: begin
                cmd.last = (idx_reg + 1'b1 == stat.ecount);
                if (stat.out_free) begin
                    cmd.op = OP_EMIT_EDGE;
                    if (cmd.last) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            ST_EMPTY: begin
                cmd.last = 1'b1;
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_EMPTY;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.op     = OP_FINISH;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/swtc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swtc_dp
// Edge buffer, sorted unique column list, slot offset table and output item.
// ----------------------------------------------------------------------------
module swtc_dp #(
    parameter int MAX_EDGES     = swtc_pkg::MAX_EDGES_DEF,
    parameter int MAX_TILE_ROWS = swtc_pkg::MAX_TILE_ROWS_DEF,
    parameter int MAX_TILE_COLS = swtc_pkg::MAX_TILE_COLS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_index,
    input  wire logic [5:0]    cfg_wdata,
    input  wire logic [3:0]    in_row,
    input  wire logic [30:0]   in_col,
    input  wire logic [31:0]   in_val,
    input  swtc_pkg::cmd_t     cmd,
    output swtc_pkg::stat_t    stat,
    input  wire logic          m_tready,
    output logic               m_tvalid,
    output logic [119:0]       m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);
    import swtc_pkg::*;

    localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [CNT_W-1:0] EDGE_CAP = CNT_W'(MAX_EDGES);
    localparam logic [4:0] ROWS_MAX = 5'(MAX_TILE_ROWS);
    localparam logic [5:0] COLS_MAX = 6'(MAX_TILE_COLS);

    logic [4:0]  rows_reg;
    logic [5:0]  cols_reg;
    logic [4:0]  eff_rows;
    logic [5:0]  eff_cols;

    logic [30:0] uc_reg   [MAX_EDGES];
    logic [30:0] uc_next  [MAX_EDGES];
    logic [30:0] ecol_mem [MAX_EDGES];
    logic [35:0] erv_mem  [MAX_EDGES];
    logic [9:0]  soff_mem [MAX_EDGES];

    logic [CNT_W-1:0] ucount_reg, ecount_reg;
    logic             drop_reg;
    logic [39:0]      total_reg;
    logic [9:0]       rc_reg, toff_reg;
    logic [5:0]       m_reg, tiles_reg;

    logic [IW-1:0]    pos_reg;
    logic [3:0]       prow_reg;
    logic [30:0]      pcol_reg;
    logic [31:0]      pval_reg;

    logic             out_valid_reg;
    logic [1:0]       okind_reg;
    logic [9:0]       ooff_reg;
    logic [30:0]      ocol_reg;
    logic [31:0]      oval_reg;
    logic             olast_reg;
    logic [5:0]       otiles_reg;
    logic [39:0]      obase_reg;
    logic             odrop_reg;

    logic             out_free, emit, keep, dup;
    logic [MAX_EDGES-1:0] lt, valid;
    logic [IW-1:0]    idx, pos;
    logic [30:0]      rd_col;
    logic [9:0]       place_off;

    assign eff_rows = (rows_reg == '0) ? 5'd1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
    assign eff_cols = (cols_reg == '0) ? 6'd1 : (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
    assign idx      = cmd.idx[IW-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (cmd.op == OP_EMIT_SLOT) || (cmd.op == OP_EMIT_EDGE)
                   || (cmd.op == OP_EMIT_EMPTY);
    assign keep     = (ecount_reg < EDGE_CAP) && ({1'b0, in_row} < eff_rows);
    assign rd_col   = ecol_mem[idx];

    assign stat.ucount   = ucount_reg;
    assign stat.ecount   = ecount_reg;
    assign stat.out_free = out_free;

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < MAX_EDGES; i++) begin
            valid[i] = (CNT_W'(i) < ucount_reg);
            lt[i]    = valid[i] && (uc_reg[i] < in_col);
            if (valid[i] && uc_reg[i] == in_col) dup = 1'b1;
        end
        for (int i = 0; i < MAX_EDGES; i++) begin
            if (lt[i])                    uc_next[i] = uc_reg[i];
            else if (i == 0)              uc_next[i] = in_col;
            else if (lt[(i > 0) ? i-1 : 0]) uc_next[i] = in_col;
            else                          uc_next[i] = uc_reg[(i > 0) ? i-1 : 0];
        end
    end

    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_EDGES; i++) begin
            if (valid[i] && uc_reg[i] == rd_col) pos = pos | IW'(i);
        end
    end

    assign place_off = soff_mem[pos_reg] + 10'(prow_reg * eff_cols);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg      <= 5'd16;
            cols_reg      <= 6'd8;
            ucount_reg    <= '0;
            ecount_reg    <= '0;
            drop_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_wdata[4:0];
                    CFG_COLS: cols_reg <= cfg_wdata;
                    default:  ;
                endcase
            end
            if (emit)          out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_INSERT: begin
                    if (!keep) begin
                        drop_reg <= 1'b1;
                    end else begin
                        ecount_reg <= ecount_reg + 1'b1;
                        if (!dup) ucount_reg <= ucount_reg + 1'b1;
                    end
                end
                OP_FINISH: begin
                    total_reg  <= total_reg + 40'(tiles_reg);
                    ucount_reg <= '0;
                    ecount_reg <= '0;
                    drop_reg   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_INSERT: begin
                if (keep) begin
                    ecol_mem[ecount_reg[IW-1:0]] <= in_col;
                    erv_mem[ecount_reg[IW-1:0]]  <= {in_row, in_val};
                    if (!dup) begin
                        for (int i = 0; i < MAX_EDGES; i++) uc_reg[i] <= uc_next[i];
                    end
                end
            end
            OP_SETUP: begin
                rc_reg    <= 10'(eff_rows * eff_cols);
                toff_reg  <= '0;
                m_reg     <= '0;
                tiles_reg <= '0;
            end
            OP_PREP: begin
                soff_mem[idx] <= toff_reg + 10'(m_reg);
                if (m_reg == '0) tiles_reg <= tiles_reg + 1'b1;
                if (m_reg == eff_cols - 1'b1) begin
                    m_reg    <= '0;
                    toff_reg <= toff_reg + rc_reg;
                end else begin
                    m_reg <= m_reg + 1'b1;
                end
            end
            OP_EDGE_RD: begin
                pos_reg  <= pos;
                pcol_reg <= rd_col;
                prow_reg <= erv_mem[idx][35:32];
                pval_reg <= erv_mem[idx][31:0];
            end
            OP_EMIT_SLOT: begin
                okind_reg <= KIND_SLOT;
                ooff_reg  <= 10'(cmd.idx);
                ocol_reg  <= uc_reg[idx];
                oval_reg  <= '0;
            end
            OP_EMIT_EDGE: begin
                okind_reg <= KIND_PLACE;
                ooff_reg  <= place_off;
                ocol_reg  <= pcol_reg;
                oval_reg  <= pval_reg;
            end
            OP_EMIT_EMPTY: begin
                okind_reg <= KIND_EMPTY;
                ooff_reg  <= '0;
                ocol_reg  <= '0;
                oval_reg  <= '0;
            end
            default: ;
        endcase
        if (emit) begin
            olast_reg  <= cmd.last;
            otiles_reg <= tiles_reg;
            obase_reg  <= total_reg;
            odrop_reg  <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {odrop_reg, obase_reg, otiles_reg, oval_reg, ocol_reg, ooff_reg};

endmodule
`default_nettype wire
